// ===== design/sbus_differential_drive_mixer_defines.svh =====
// assertion macros for the sbus mixer
`ifndef SBUS_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define SBUS_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
// implication checked every clock, off during reset
`define SDM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SDM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/sdm_pkg.sv =====
// package for the sbus mixer: widths, codes and reset values
`default_nettype none
package sdm_pkg;
    localparam int FULL_SCALE_DEF = 2048;
    localparam int RAW_W = 11;
    localparam int GAIN_SHIFT = 10;
    localparam logic [4:0] IDLE_COUNT = 5'd24;
    localparam logic [4:0] FLAGS_POS = 5'd23;
    localparam logic [2:0] REG_STEER_MIN = 3'd0;
    localparam logic [2:0] REG_STEER_MAX = 3'd1;
    localparam logic [2:0] REG_DRIVE_MIN = 3'd2;
    localparam logic [2:0] REG_DRIVE_MAX = 3'd3;
    localparam logic [2:0] REG_GAIN_MIN = 3'd4;
    localparam logic [2:0] REG_GAIN_MAX = 3'd5;
    localparam logic [10:0] RST_STEER_MIN = 11'd172;
    localparam logic [10:0] RST_STEER_MAX = 11'd1811;
    localparam logic [10:0] RST_DRIVE_MIN = 11'd160;
    localparam logic [10:0] RST_DRIVE_MAX = 11'd1792;
    localparam logic [10:0] RST_GAIN_MIN = 11'd172;
    localparam logic [10:0] RST_GAIN_MAX = 11'd1808;
endpackage
`default_nettype wire

// ===== design/sdm_divider.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module sdm_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign quot  = q_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                if (!diff[DEN_W])
                begin
                    rem_reg <= diff;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/sdm_multiplier.sv =====
// serial shift-add signed by unsigned multiplier, one multiplier bit per cycle
`default_nettype none
module sdm_multiplier #(
    parameter int A_W = 14,
    parameter int B_W = 15
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [A_W-1:0] a,
    input  wire logic [B_W-1:0]        b,
    output logic                       done,
    output logic signed [A_W+B_W-1:0]  prod
);
    localparam int CNT_W = $clog2(B_W + 1);
    logic signed [A_W+B_W-1:0] acc_reg;
    logic signed [A_W+B_W-1:0] a_reg;
    logic [B_W-1:0]            b_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    assign prod = acc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                acc_reg  <= '0;
                a_reg    <= (A_W+B_W)'(a);
                b_reg    <= b;
                cnt_reg  <= CNT_W'(B_W);
            end
            else if (busy_reg)
            begin
                if (b_reg[0])
                    acc_reg <= acc_reg + a_reg;
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/sbus_differential_drive_mixer.sv =====
// top level: sbus frame decode, serial calibration and differential mixing
// usage:
//   input channel: frame_byte and frame_start with in_valid / in_stall.
//   frame_start marks the header byte and restarts the byte count. bytes
//   1..5 carry channels 0..2; byte 23 (flags) closes the frame and yields
//   one result item; all other bytes yield nothing.
//   output channel: duty values, direction pins and both flags with
//   out_valid / out_stall. a result is held in the output register until taken.
// sequence:
//   on the flags byte, three calibrations run in turn through one bit-serial
//   divider, then two products through one serial multiplier; then the duty
//   and pin registers are loaded and out_valid is raised. other bytes are
//   taken without a calculation. the shared divider and multiplier keep one
//   item in flight: no new byte is taken until the result is taken.
// reset: byte count idles at 24, duties and pins are cleared, registers take
//   their reset calibration values, no result is pending.
// stall: in_stall stays high while a frame is computed or a result waits.
`include "sbus_differential_drive_mixer_defines.svh"
`default_nettype none
module sbus_differential_drive_mixer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      left_duty,
    output logic             left_forward,
    output logic             left_backward,
    output logic [11:0]      right_duty,
    output logic             right_forward,
    output logic             right_backward,
    output logic             lost_frame,
    output logic             fail_safe
);
    localparam int FULL_SCALE = sdm_pkg::FULL_SCALE_DEF;
    localparam int FS_W  = $clog2(FULL_SCALE) + 1;       // holds FULL_SCALE
    localparam int SH    = $clog2(FULL_SCALE);
    localparam int NUM_W = sdm_pkg::RAW_W + SH;           // (raw-min)*FULL_SCALE
    localparam int SUM_W = FS_W + 2;                      // signed mixer sum
    localparam int PRD_W = SUM_W + FS_W;
    localparam logic signed [PRD_W-1:0] FS_POS = PRD_W'(FULL_SCALE);
    localparam logic signed [PRD_W-1:0] FS_NEG = -PRD_W'(FULL_SCALE);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2,
        S_MUL0, S_WAITM0, S_MUL1, S_WAITM1, S_OUT
    } state_t;

    state_t state_reg;
    logic [10:0] cfg_reg [6];
    logic [4:0]  count_reg;
    logic [7:0]  bytes_reg [5];
    logic [11:0] ld_reg, rd_reg;
    logic [1:0]  lp_reg, rp_reg;
    logic        lost_reg, fs_reg, ov_reg;
    logic [FS_W-1:0] c_reg [3];
    logic signed [PRD_W-1:0] lpow_reg;

    // config port
    logic [2:0] widx;
    assign widx = paddr[4:2];
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (widx < 3'd6)
            prdata = {21'd0, cfg_reg[widx]};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[sdm_pkg::REG_STEER_MIN] <= sdm_pkg::RST_STEER_MIN;
            cfg_reg[sdm_pkg::REG_STEER_MAX] <= sdm_pkg::RST_STEER_MAX;
            cfg_reg[sdm_pkg::REG_DRIVE_MIN] <= sdm_pkg::RST_DRIVE_MIN;
            cfg_reg[sdm_pkg::REG_DRIVE_MAX] <= sdm_pkg::RST_DRIVE_MAX;
            cfg_reg[sdm_pkg::REG_GAIN_MIN]  <= sdm_pkg::RST_GAIN_MIN;
            cfg_reg[sdm_pkg::REG_GAIN_MAX]  <= sdm_pkg::RST_GAIN_MAX;
        end
        else if (psel && penable && pwrite && widx < 3'd6)
            cfg_reg[widx] <= pwdata[10:0];
    end

    // raw channel unpack
    logic [10:0] raw [3];
    assign raw[0] = {bytes_reg[1][2:0], bytes_reg[0]};
    assign raw[1] = {bytes_reg[2][5:0], bytes_reg[1][7:3]};
    assign raw[2] = {bytes_reg[4][0], bytes_reg[3], bytes_reg[2][7:6]};

    // calibration through one shared divider
    logic [1:0] ch_sel;
    logic [10:0] lo, hi;
    logic div_start, div_done;
    logic [NUM_W-1:0] quot;
    logic bad_cal;
    always_comb
    begin
        case (state_reg)
            S_DIV1, S_WAIT1: ch_sel = 2'd1;
            S_DIV2, S_WAIT2: ch_sel = 2'd2;
            default:         ch_sel = 2'd0;
        endcase
    end
    assign lo = cfg_reg[{ch_sel, 1'b0}];
    assign hi = cfg_reg[{ch_sel, 1'b1}];
    assign bad_cal = (hi <= lo) || (raw[ch_sel] <= lo);
    assign div_start = (state_reg == S_DIV0) || (state_reg == S_DIV1)
                    || (state_reg == S_DIV2);
    sdm_divider #(.NUM_W(NUM_W), .DEN_W(sdm_pkg::RAW_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num({raw[ch_sel] - lo, {SH{1'b0}}}), .den(hi - lo),
        .done(div_done), .quot(quot)
    );
    logic [FS_W-1:0] cal_val;
    always_comb
    begin
        if (bad_cal)
            cal_val = '0;
        else if (quot > NUM_W'(FULL_SCALE))
            cal_val = FS_W'(FULL_SCALE);
        else
            cal_val = quot[FS_W-1:0];
    end

    // mixing through one shared multiplier
    logic signed [SUM_W-1:0] c0s, c1s, mix_a;
    logic mul_start, mul_done;
    logic signed [PRD_W-1:0] prod, pow, pclamp;
    assign c0s = SUM_W'(c_reg[0]);
    assign c1s = SUM_W'(c_reg[1]);
    assign mix_a = (state_reg == S_MUL0 || state_reg == S_WAITM0)
                 ? (c1s + c0s - SUM_W'(FULL_SCALE)) : (c1s - c0s);
    assign mul_start = (state_reg == S_MUL0) || (state_reg == S_MUL1);
    sdm_multiplier #(.A_W(SUM_W), .B_W(FS_W)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mix_a), .b(c_reg[2]),
        .done(mul_done), .prod(prod)
    );
    // truncate toward zero on the gain divide
    assign pow = (prod < 0) ? -((-prod) >>> sdm_pkg::GAIN_SHIFT)
                            : (prod >>> sdm_pkg::GAIN_SHIFT);
    assign pclamp = (pow > FS_POS) ? FS_POS : ((pow < FS_NEG) ? FS_NEG : pow);

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = ov_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    logic [4:0] cnt_inc;
    assign cnt_inc = count_reg + 5'd1;
    logic signed [PRD_W-1:0] rneg, lneg;
    assign lneg = -lpow_reg;
    assign rneg = -pclamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= sdm_pkg::IDLE_COUNT;
            ld_reg <= '0;
            rd_reg <= '0;
            lp_reg <= '0;
            rp_reg <= '0;
            ov_reg <= 1'b0;
            lost_reg <= 1'b0;
            fs_reg <= 1'b0;
        end
        else
        begin
            if (out_acc)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (frame_start)
                            count_reg <= '0;
                        else if (count_reg < sdm_pkg::IDLE_COUNT)
                        begin
                            count_reg <= cnt_inc;
                            if (cnt_inc >= 5'd1 && cnt_inc <= 5'd5)
                                bytes_reg[cnt_inc[2:0] - 3'd1] <= frame_byte;
                            if (cnt_inc == sdm_pkg::FLAGS_POS)
                            begin
                                lost_reg  <= frame_byte[2];
                                fs_reg    <= frame_byte[3];
                                state_reg <= S_DIV0;
                            end
                        end
                    end
                end
                S_DIV0: state_reg <= S_WAIT0;
                S_WAIT0:
                    if (div_done)
                    begin
                        c_reg[0] <= cal_val;
                        state_reg <= S_DIV1;
                    end
                S_DIV1: state_reg <= S_WAIT1;
                S_WAIT1:
                    if (div_done)
                    begin
                        c_reg[1] <= cal_val;
                        state_reg <= S_DIV2;
                    end
                S_DIV2: state_reg <= S_WAIT2;
                S_WAIT2:
                    if (div_done)
                    begin
                        c_reg[2] <= cal_val;
                        state_reg <= S_MUL0;
                    end
                S_MUL0: state_reg <= S_WAITM0;
                S_WAITM0:
                    if (mul_done)
                    begin
                        lpow_reg <= pclamp;
                        state_reg <= S_MUL1;
                    end
                S_MUL1: state_reg <= S_WAITM1;
                S_WAITM1:
                    if (mul_done)
                    begin
                        if (lost_reg)
                        begin
                            ld_reg <= '0;
                            rd_reg <= '0;
                        end
                        else
                        begin
                            if (lpow_reg > 0)
                            begin
                                lp_reg <= 2'b01;
                                ld_reg <= lpow_reg[11:0];
                            end
                            else if (lpow_reg < 0)
                            begin
                                lp_reg <= 2'b10;
                                ld_reg <= lneg[11:0];
                            end
                            if (pclamp > 0)
                            begin
                                rp_reg <= 2'b01;
                                rd_reg <= pclamp[11:0];
                            end
                            else if (pclamp < 0)
                            begin
                                rp_reg <= 2'b10;
                                rd_reg <= rneg[11:0];
                            end
                        end
                        state_reg <= S_OUT;
                    end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = ov_reg;
    assign left_duty      = ld_reg;
    assign left_forward   = lp_reg[0];
    assign left_backward  = lp_reg[1];
    assign right_duty     = rd_reg;
    assign right_forward  = rp_reg[0];
    assign right_backward = rp_reg[1];
    assign lost_frame     = lost_reg;
    assign fail_safe      = fs_reg;

    `SDM_ASSERT_IMP(a_no_accept_busy, state_reg != S_IDLE, in_stall)
    `SDM_ASSERT_IMP(a_pins_exclusive, 1'b1, !(lp_reg == 2'b11) && !(rp_reg == 2'b11))
    `SDM_ASSERT_NXT(a_out_after_mix, state_reg == S_OUT, ov_reg)
endmodule
`default_nettype wire

// ===== test/sbus_differential_drive_mixer_tb.sv =====
// testbench for the sbus frame decoder with differential drive mixing
`timescale 1ns / 1ps
module sbus_differential_drive_mixer_tb;

    localparam int FS = sdm_pkg::FULL_SCALE_DEF;
    localparam int SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 2000000;

    // one result item as seen on the output port
    typedef struct packed {
        logic [11:0] left_duty;
        logic        left_fwd;
        logic        left_bwd;
        logic [11:0] right_duty;
        logic        right_fwd;
        logic        right_bwd;
        logic        lost;
        logic        fsafe;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] frame_byte = '0;
    logic frame_start = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [11:0] left_duty, right_duty;
    logic left_forward, left_backward, right_forward, right_backward;
    logic lost_frame, fail_safe;

    sbus_differential_drive_mixer u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .frame_byte(frame_byte), .frame_start(frame_start),
        .out_valid(out_valid), .out_stall(out_stall),
        .left_duty(left_duty), .left_forward(left_forward),
        .left_backward(left_backward), .right_duty(right_duty),
        .right_forward(right_forward), .right_backward(right_backward),
        .lost_frame(lost_frame), .fail_safe(fail_safe)
    );

    always #5 clk = ~clk;

    // predictor state: calibration registers and the block's own registers
    logic [10:0] cal_lo [3];
    logic [10:0] cal_hi [3];
    int unsigned frame_pos;
    logic [7:0] chan_bytes [5];
    logic [11:0] left_duty_q, right_duty_q;
    logic [1:0] left_pins_q, right_pins_q;

    drive_result_t expected_drive [$];
    int unsigned fail_count = 0;
    longint cycle_count = 0;

    // idle percentages for the sender and the receiver
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;

    function automatic longint calibrate_raw(logic [10:0] raw, logic [10:0] lo,
                                             logic [10:0] hi);
        longint v;
        if (hi <= lo || raw <= lo)
            return 0;
        v = (longint'(raw - lo) * FS) / longint'(hi - lo);
        return (v > FS) ? FS : v;
    endfunction

    function automatic longint clamp_power(longint p);
        if (p > FS)
            return FS;
        if (p < -FS)
            return -FS;
        return p;
    endfunction

    task automatic apply_side(longint p, ref logic [11:0] duty, ref logic [1:0] pins);
        if (p > 0)
        begin
            pins = 2'b01;
            duty = p[11:0];
        end
        else if (p < 0)
        begin
            pins = 2'b10;
            duty = 12'(-p);
        end
    endtask

    // advance the frame decoder by one accepted item
    task automatic predict_byte(logic [7:0] b, logic start);
        logic [10:0] r0, r1, r2;
        longint c0, c1, c2, lp, rp;
        drive_result_t res;
        if (start)
        begin
            frame_pos = 0;
            return;
        end
        if (frame_pos >= 24)
            return;
        frame_pos++;
        if (frame_pos <= 5)
            chan_bytes[frame_pos - 1] = b;
        if (frame_pos != 23)
            return;
        r0 = {chan_bytes[1][2:0], chan_bytes[0]};
        r1 = {chan_bytes[2][5:0], chan_bytes[1][7:3]};
        r2 = {chan_bytes[4][0], chan_bytes[3], chan_bytes[2][7:6]};
        c0 = calibrate_raw(r0, cal_lo[0], cal_hi[0]);
        c1 = calibrate_raw(r1, cal_lo[1], cal_hi[1]);
        c2 = calibrate_raw(r2, cal_lo[2], cal_hi[2]);
        lp = clamp_power(((c1 + c0 - FS) * c2) / 1024);
        rp = clamp_power(((c1 - c0) * c2) / 1024);
        if (b[2])
        begin
            left_duty_q = '0;
            right_duty_q = '0;
        end
        else
        begin
            apply_side(lp, left_duty_q, left_pins_q);
            apply_side(rp, right_duty_q, right_pins_q);
        end
        res.left_duty = left_duty_q;
        res.left_fwd = left_pins_q[0];
        res.left_bwd = left_pins_q[1];
        res.right_duty = right_duty_q;
        res.right_fwd = right_pins_q[0];
        res.right_bwd = right_pins_q[1];
        res.lost = b[2];
        res.fsafe = b[3];
        expected_drive.push_back(res);
    endtask

    // send one item, honoring the sender gap setting
    task automatic send_byte(logic [7:0] b, logic start);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_byte <= b;
        frame_start <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, start);
    endtask

    // a full frame: header, 22 data bytes, flags byte
    task automatic send_frame(logic [10:0] ch0, logic [10:0] ch1, logic [10:0] ch2,
                              logic [7:0] flags);
        logic [7:0] bytes [22];
        logic [32:0] packed_ch;
        packed_ch = {ch2, ch1, ch0};
        foreach (bytes[i])
            bytes[i] = 8'($urandom_range(255));
        for (int i = 0; i < 4; i++)
            bytes[i] = packed_ch[i*8 +: 8];
        bytes[4] = {bytes[4][7:1], packed_ch[32]};
        send_byte(8'($urandom_range(255)), 1'b1);
        foreach (bytes[i])
            send_byte(bytes[i], 1'b0);
        send_byte(flags, 1'b0);
    endtask

    // register write: setup then access
    task automatic write_cal(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx[0])
            cal_hi[idx >> 1] = value[10:0];
        else
            cal_lo[idx >> 1] = value[10:0];
    endtask

    // wait for all results, then the worst case compute time
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_all_cal(logic [10:0] smin, logic [10:0] smax, logic [10:0] dmin,
                               logic [10:0] dmax, logic [10:0] gmin, logic [10:0] gmax);
        drain_results();
        write_cal(sdm_pkg::REG_STEER_MIN, {21'($urandom_range(2097151)), smin});
        write_cal(sdm_pkg::REG_STEER_MAX, {21'd0, smax});
        write_cal(sdm_pkg::REG_DRIVE_MIN, {21'd0, dmin});
        write_cal(sdm_pkg::REG_DRIVE_MAX, {21'd0, dmax});
        write_cal(sdm_pkg::REG_GAIN_MIN, {21'd0, gmin});
        write_cal(sdm_pkg::REG_GAIN_MAX, {21'($urandom_range(2097151)), gmax});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    logic [7:0] rand_flags;

    // directed: extremes of the channels, lost frame, failsafe, zero power
    task automatic test_directed();
        send_frame(11'd0, 11'd0, 11'd0, 8'h00);
        send_frame(11'h7FF, 11'h7FF, 11'h7FF, 8'h00);
        send_frame(11'd172, 11'h7FF, 11'h7FF, 8'h08);
        send_frame(11'h7FF, 11'd160, 11'h7FF, 8'hF3);
        send_frame(11'd991, 11'd976, 11'd1808, 8'h00);
        send_frame(11'h7FF, 11'h7FF, 11'h7FF, 8'h04);
        send_frame(11'd1000, 11'd1000, 11'd172, 8'h0C);
        // stray bytes after a frame, before the next frame start, are ignored
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // restart in the middle of a frame
        send_byte(8'h0F, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_frame(11'd1500, 11'd300, 11'd1200, 8'hFF);
    endtask

    // bad calibration: max equal to min, max below min, raw at min, narrow ranges
    task automatic test_bad_calibration();
        set_all_cal(11'd500, 11'd500, 11'h7FF, 11'd0, 11'd0, 11'd0);
        send_frame(11'd900, 11'd900, 11'd900, 8'h00);
        send_frame(11'h7FF, 11'd0, 11'h7FF, 8'h00);
        set_all_cal(11'd0, 11'h7FF, 11'd0, 11'h7FF, 11'd0, 11'h7FF);
        send_frame(11'h7FF, 11'h7FF, 11'h7FF, 8'h00);
        send_frame(11'd0, 11'h7FF, 11'h7FF, 8'h00);
        send_frame(11'h7FF, 11'd0, 11'h7FF, 8'h00);
        set_all_cal(11'd2046, 11'h7FF, 11'd0, 11'd1, 11'd1000, 11'd1001);
        send_frame(11'h7FF, 11'h7FF, 11'h7FF, 8'h00);
        send_frame(11'd2046, 11'd1, 11'd1001, 8'h00);
    endtask

    // random frames, mostly well formed, some noise and broken frames
    task automatic test_random(int unsigned n_frames);
        for (int f = 0; f < n_frames; f++)
        begin
            rand_flags = 8'($urandom_range(255));
            case ($urandom_range(9))
                0:
                begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                    send_byte(8'($urandom_range(255)), 1'b0);
                end
                1:
                begin
                    send_byte(8'($urandom_range(255)), 1'b1);
                    repeat ($urandom_range(22)) send_byte(8'($urandom_range(255)), 1'b0);
                end
                2:
                    send_frame(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                               11'($urandom_range(2047)),
                               {rand_flags[7:3], 1'b0, rand_flags[1:0]});
                default:
                    send_frame(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                               11'($urandom_range(2047)), rand_flags);
            endcase
        end
    endtask

    // result checker and receiver stall generator
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("result with no item expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (left_duty !== want.left_duty)
                    begin
                        $error("left_duty expected %0d actual %0d", want.left_duty, left_duty);
                        fail_count++;
                    end
                    if (left_forward !== want.left_fwd)
                    begin
                        $error("left_forward expected %0d actual %0d", want.left_fwd,
                               left_forward);
                        fail_count++;
                    end
                    if (left_backward !== want.left_bwd)
                    begin
                        $error("left_backward expected %0d actual %0d", want.left_bwd,
                               left_backward);
                        fail_count++;
                    end
                    if (right_duty !== want.right_duty)
                    begin
                        $error("right_duty expected %0d actual %0d", want.right_duty,
                               right_duty);
                        fail_count++;
                    end
                    if (right_forward !== want.right_fwd)
                    begin
                        $error("right_forward expected %0d actual %0d", want.right_fwd,
                               right_forward);
                        fail_count++;
                    end
                    if (right_backward !== want.right_bwd)
                    begin
                        $error("right_backward expected %0d actual %0d", want.right_bwd,
                               right_backward);
                        fail_count++;
                    end
                    if (lost_frame !== want.lost)
                    begin
                        $error("lost_frame expected %0d actual %0d", want.lost, lost_frame);
                        fail_count++;
                    end
                    if (fail_safe !== want.fsafe)
                    begin
                        $error("fail_safe expected %0d actual %0d", want.fsafe, fail_safe);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sbus_differential_drive_mixer_tb failed");
            $finish;
        end
    end

    initial
    begin
        cal_lo[0] = sdm_pkg::RST_STEER_MIN;
        cal_hi[0] = sdm_pkg::RST_STEER_MAX;
        cal_lo[1] = sdm_pkg::RST_DRIVE_MIN;
        cal_hi[1] = sdm_pkg::RST_DRIVE_MAX;
        cal_lo[2] = sdm_pkg::RST_GAIN_MIN;
        cal_hi[2] = sdm_pkg::RST_GAIN_MAX;
        frame_pos = 24;
        foreach (chan_bytes[i])
            chan_bytes[i] = '0;
        left_duty_q = '0;
        right_duty_q = '0;
        left_pins_q = '0;
        right_pins_q = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_gap_pct = 10;
        recv_stall_pct = 77;
        test_directed();
        test_bad_calibration();
        set_all_cal(sdm_pkg::RST_STEER_MIN, sdm_pkg::RST_STEER_MAX, sdm_pkg::RST_DRIVE_MIN,
                    sdm_pkg::RST_DRIVE_MAX, sdm_pkg::RST_GAIN_MIN, sdm_pkg::RST_GAIN_MAX);
        test_random(11);
        // swapped idling, random calibration
        send_gap_pct = 77;
        recv_stall_pct = 10;
        set_all_cal(11'($urandom_range(600)), 11'(1400 + $urandom_range(647)),
                    11'($urandom_range(600)), 11'(1400 + $urandom_range(647)),
                    11'($urandom_range(600)), 11'(1400 + $urandom_range(647)));
        test_random(11);
        // no idling on either side
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_all_cal(sdm_pkg::RST_STEER_MIN, sdm_pkg::RST_STEER_MAX, sdm_pkg::RST_DRIVE_MIN,
                    sdm_pkg::RST_DRIVE_MAX, sdm_pkg::RST_GAIN_MIN, sdm_pkg::RST_GAIN_MAX);
        test_random(11);

        drain_results();
        if (fail_count == 0)
            $display("sbus_differential_drive_mixer_tb passed");
        else
            $display("sbus_differential_drive_mixer_tb failed");
        $finish;
    end
endmodule
